/* src/nid_pkg.sv */
// Shared types, constants and checksum helper for the ingress DNAT rewrite block.
package nid_pkg;

    localparam int TABLE_ENTRIES = 4096;
    localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

    localparam logic [31:0] WAN_RESET      = 32'h0A00_0002;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [15:0] ETH_HDR_LEN    = 16'd14;
    localparam logic [15:0] IP_HDR_END     = 16'd34;
    localparam logic [15:0] UDP_HDR_END    = 16'd42;
    localparam logic [15:0] TCP_HDR_END    = 16'd54;

    localparam logic MODE_HEADER = 1'b0;
    localparam logic MODE_WRITE  = 1'b1;

    localparam logic [1:0] V_DROP    = 2'd0;
    localparam logic [1:0] V_PASS    = 2'd1;
    localparam logic [1:0] V_REWRITE = 2'd2;
    localparam logic [1:0] V_WRITE   = 2'd3;

    localparam logic [1:0] K_DROP   = 2'd0;
    localparam logic [1:0] K_PASS   = 2'd1;
    localparam logic [1:0] K_LOOKUP = 2'd2;
    localparam logic [1:0] K_WRITE  = 2'd3;

    typedef struct packed {
        logic        mode;
        logic [15:0] frame_length;
        logic [15:0] ether_type;
        logic [7:0]  ip_protocol;
        logic [31:0] dest_ip;
        logic [15:0] dest_port;
        logic [15:0] ip_checksum;
        logic [15:0] l4_checksum;
        logic [15:0] entry_wan_port;
        logic [31:0] entry_lan_ip;
        logic [15:0] entry_lan_port;
        logic [7:0]  entry_protocol;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [31:0] new_dest_ip;
        logic [15:0] new_dest_port;
        logic [15:0] new_ip_checksum;
        logic [15:0] new_l4_checksum;
        logic        entry_replaced;
    } t_out_item;

    typedef struct packed {
        logic [1:0]        kind;
        logic              is_tcp;
        logic [SLOT_W-1:0] slot;
        t_in_item          item;
    } t_job;

    // end-around fold of a sum of up to fifteen 16-bit words
    function automatic logic [15:0] csum_fold(input logic [19:0] s);
        logic [16:0] t;
        t = {1'b0, s[15:0]} + {13'd0, s[19:16]};
        return t[15:0] + {15'd0, t[16]};
    endfunction

endpackage

/* src/nat_ingress_dest_rewrite.sv */
// Top level of the ingress destination NAT rewrite block.
//
//  channel  | signals                               | direction
//  ---------+---------------------------------------+----------
//  input    | i_valid, o_stall, i_item (t_in_item)  | in
//  output   | o_valid, i_stall, o_item (t_out_item) | out
//  config   | i_cfg_valid, o_cfg_ready, i_cfg_data  | in
//
// The front end takes one item per cycle into a two-entry queue while
// o_stall is low. The back end reads the table in idle, then compares,
// updates checksums and writes the table back in exec; it pops the next
// item only in idle. After reset a pass over all 4096 entries clears the
// table valid bits while o_stall is held high. The output register holds
// its item while i_stall is high; the queue absorbs input meanwhile.
module nat_ingress_dest_rewrite
    import nid_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_in_item    i_item,
    output logic        o_stall,
    output logic        o_valid,
    output t_out_item   o_item,
    input  logic        i_stall,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    logic q_push;
    logic q_full;
    logic q_valid;
    logic q_pop;
    logic clearing;
    t_job push_job;
    t_job head_job;

    nid_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_item      (i_item),
        .o_stall     (o_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_hold      (clearing),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_job       (push_job)
    );

    nid_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (head_job),
        .i_pop   (q_pop)
    );

    nid_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_data   (head_job),
        .o_pop      (q_pop),
        .o_clearing (clearing),
        .o_valid    (o_valid),
        .o_item     (o_item),
        .i_stall    (i_stall)
    );

endmodule

/* src/nid_front.sv */
// Front end: accepts items, holds the WAN address register and classifies headers.
module nid_front
    import nid_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_in_item    i_item,
    output logic        o_stall,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    input  logic        i_hold,
    input  logic        i_q_full,
    output logic        o_push,
    output t_job        o_job
);

    logic [31:0] r_wan;
    logic [1:0]  n_kind;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = i_q_full | i_hold;
    assign o_push      = i_valid & ~o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wan <= WAN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_wan <= i_cfg_data;
        end
    end

    always_comb begin
        if (i_item.mode == MODE_WRITE) begin
            n_kind = K_WRITE;
        end else if (i_item.frame_length < ETH_HDR_LEN) begin
            n_kind = K_DROP;
        end else if (i_item.ether_type != ETHERTYPE_IPV4) begin
            n_kind = K_PASS;
        end else if (i_item.frame_length < IP_HDR_END) begin
            n_kind = K_DROP;
        end else if (i_item.dest_ip != r_wan) begin
            n_kind = K_DROP;
        end else if (i_item.ip_protocol == PROTO_UDP) begin
            n_kind = (i_item.frame_length < UDP_HDR_END) ? K_DROP : K_LOOKUP;
        end else if (i_item.ip_protocol == PROTO_TCP) begin
            n_kind = (i_item.frame_length < TCP_HDR_END) ? K_DROP : K_LOOKUP;
        end else begin
            n_kind = K_PASS;
        end
    end

    always_comb begin
        o_job.kind   = n_kind;
        o_job.is_tcp = (i_item.ip_protocol == PROTO_TCP);
        o_job.slot   = (i_item.mode == MODE_WRITE) ? i_item.entry_wan_port[SLOT_W-1:0]
                                                   : i_item.dest_port[SLOT_W-1:0];
        o_job.item   = i_item;
    end

endmodule

/* src/nid_queue.sv */
// Short job queue between the classifying front end and the table back end.
module nid_queue
    import nid_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    output logic o_valid,
    output t_job o_data,
    input  logic i_pop
);

    t_job              r_slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slots[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push || i_pop)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

/* src/nid_back.sv */
// Back end: mapping table, clear pass, lookup, checksum update and output register.
module nid_back
    import nid_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_job      i_q_data,
    output logic      o_pop,
    output logic      o_clearing,
    output logic      o_valid,
    output t_out_item o_item,
    input  logic      i_stall
);

    typedef struct packed {
        logic        valid;
        logic [15:0] tag;
        logic [31:0] lan_ip;
        logic [15:0] lan_port;
        logic [7:0]  proto;
    } t_entry;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    t_entry            r_mem [TABLE_ENTRIES];
    t_entry            r_rd;
    t_job              r_cur;
    logic              r_state;
    logic              r_clearing;
    logic [SLOT_W-1:0] r_clr_addr;
    logic              r_out_valid;
    t_out_item         r_out;

    t_out_item         n_out;
    logic              out_free;
    logic              do_exec;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_wa;
    t_entry            mem_wd;
    logic              hit;
    logic [19:0]       ip_sum;
    logic [19:0]       tcp_sum;
    logic [15:0]       wport;

    assign out_free   = !r_out_valid || !i_stall;
    assign do_exec    = (r_state == S_EXEC) && out_free;
    assign o_pop      = (r_state == S_IDLE) && !r_clearing && i_q_valid;
    assign o_clearing = r_clearing;
    assign o_valid    = r_out_valid;
    assign o_item     = r_out;
    assign wport      = r_cur.item.entry_wan_port;

    assign hit = r_rd.valid && (r_rd.tag == r_cur.item.dest_port)
               && (r_rd.proto == r_cur.item.ip_protocol);

    assign ip_sum = {4'd0, ~r_cur.item.ip_checksum}
                  + {4'd0, ~r_cur.item.dest_ip[31:16]}
                  + {4'd0, ~r_cur.item.dest_ip[15:0]}
                  + {4'd0, r_rd.lan_ip[31:16]}
                  + {4'd0, r_rd.lan_ip[15:0]};

    assign tcp_sum = {4'd0, ~r_cur.item.l4_checksum}
                   + {4'd0, ~r_cur.item.dest_ip[31:16]}
                   + {4'd0, ~r_cur.item.dest_ip[15:0]}
                   + {4'd0, r_rd.lan_ip[31:16]}
                   + {4'd0, r_rd.lan_ip[15:0]}
                   + {4'd0, ~r_cur.item.dest_port}
                   + {4'd0, r_rd.lan_port};

    always_comb begin
        n_out.verdict         = V_PASS;
        n_out.new_dest_ip     = r_cur.item.dest_ip;
        n_out.new_dest_port   = r_cur.item.dest_port;
        n_out.new_ip_checksum = r_cur.item.ip_checksum;
        n_out.new_l4_checksum = r_cur.item.l4_checksum;
        n_out.entry_replaced  = 1'b0;
        case (r_cur.kind)
            K_DROP: begin
                n_out.verdict = V_DROP;
            end
            K_PASS: begin
                n_out.verdict = V_PASS;
            end
            K_LOOKUP: begin
                if (hit) begin
                    n_out.verdict         = V_REWRITE;
                    n_out.new_dest_ip     = r_rd.lan_ip;
                    n_out.new_dest_port   = r_rd.lan_port;
                    n_out.new_ip_checksum = ~csum_fold(ip_sum);
                    n_out.new_l4_checksum = r_cur.is_tcp ? ~csum_fold(tcp_sum) : 16'd0;
                end
            end
            K_WRITE: begin
                n_out.verdict         = V_WRITE;
                n_out.new_dest_ip     = '0;
                n_out.new_dest_port   = '0;
                n_out.new_ip_checksum = '0;
                n_out.new_l4_checksum = '0;
                n_out.entry_replaced  = r_rd.valid && (r_rd.tag != wport);
            end
            default: begin
                n_out.verdict = V_PASS;
            end
        endcase
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_cur.slot;
        mem_wd.valid    = 1'b1;
        mem_wd.tag      = wport;
        mem_wd.lan_ip   = r_cur.item.entry_lan_ip;
        mem_wd.lan_port = r_cur.item.entry_lan_port;
        mem_wd.proto    = r_cur.item.entry_protocol;
        if (r_clearing) begin
            mem_we       = 1'b1;
            mem_wa       = r_clr_addr;
            mem_wd.valid = 1'b0;
        end else if (do_exec && r_cur.kind == K_WRITE) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (o_pop) begin
            r_rd <= r_mem[i_q_data.slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_q_data;
        end
        if (do_exec) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    r_clearing <= 1'b0;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (do_exec) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (do_exec) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> (r_state == S_IDLE) && !o_pop)
        else $error("job started during table clear");

    a_pop_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == S_EXEC))
        else $error("popped job not executed");

    a_exec_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_exec |=> r_out_valid && (r_state == S_IDLE))
        else $error("executed job did not reach output");

endmodule
